[hdl/rip_pkg.sv]
// Shared types, constants and character helpers for the radix integer parser.
`timescale 1ns / 1ps

package rip_pkg;

   localparam int CHAR_W  = 8;
   localparam int RADIX_W = 6;
   localparam int ACC_W   = 64;
   localparam int DIGIT_W = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;

   // Digit value reported for a character that is a digit of no radix.
   localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd64;
   localparam logic [DIGIT_W-1:0] LETTER_BASE = 7'd10;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_INT,
      PH_TAIL,
      PH_BAD
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [ACC_W-1:0]  acc;
      logic              negative;
      logic              overflowed;
   } parse_state_type;

   typedef struct packed {
      logic              overflow;
      logic              valid_res;
      logic [ACC_W-1:0]  value;
   } result_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase: PH_LEAD, acc: '0, negative: 1'b0, overflowed: 1'b0};

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_TAB);
   endfunction

   function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = DIGIT_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         d = DIGIT_W'(c - CHAR_UC_A) + LETTER_BASE;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         d = DIGIT_W'(c - CHAR_LC_A) + LETTER_BASE;
      end else begin
         d = NOT_DIGIT;
      end
      return d;
   endfunction

endpackage

[hdl/rip_step.sv]
// Per-character parse step: phase transition, multiply-accumulate and result.
`timescale 1ns / 1ps

module rip_step
   import rip_pkg::*;
(
   input  logic [CHAR_W-1:0]  char_code,
   input  logic [RADIX_W-1:0] radix,
   input  parse_state_type    cur_state,
   output parse_state_type    next_state,
   output result_type         result
);

   logic [DIGIT_W-1:0]   digit;
   logic                 digit_ok;
   logic                 blank;
   logic                 sign;
   logic                 take_digit;
   logic                 take_sign;
   phase_type            phase_next;
   logic [ACC_W+5:0]     product;
   logic [ACC_W+6:0]     mac_sum;
   logic                 carry;
   logic                 literal_ok;

   assign digit    = digit_value(char_code);
   assign digit_ok = digit < {1'b0, radix};
   assign blank    = is_blank(char_code);
   assign sign     = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);

   // Next phase.
   always_comb begin
      phase_next = PH_BAD;
      unique case (cur_state.phase)
         PH_LEAD: begin
            if (blank) phase_next = PH_LEAD;
            else if (digit_ok) phase_next = PH_INT;
            else if (sign) phase_next = PH_SIGN;
            else phase_next = PH_BAD;
         end
         PH_SIGN: begin
            phase_next = digit_ok ? PH_INT : PH_BAD;
         end
         PH_INT: begin
            if (digit_ok) phase_next = PH_INT;
            else if (blank) phase_next = PH_TAIL;
            else phase_next = PH_BAD;
         end
         PH_TAIL: begin
            phase_next = blank ? PH_TAIL : PH_BAD;
         end
         default: begin
            phase_next = PH_BAD;
         end
      endcase
   end

   // Datapath controls decoded from the current phase.
   always_comb begin
      take_digit = 1'b0;
      take_sign  = 1'b0;
      unique case (cur_state.phase)
         PH_LEAD: begin
            take_digit = !blank && digit_ok;
            take_sign  = !blank && !digit_ok && sign;
         end
         PH_SIGN, PH_INT: begin
            take_digit = digit_ok;
         end
         default: begin
            take_digit = 1'b0;
         end
      endcase
   end

   // The magnitude overflows exactly when acc * radix + digit needs more than 64 bits.
   assign product = {6'b0, cur_state.acc} * {{(ACC_W){1'b0}}, radix};
   assign mac_sum = {1'b0, product} + (ACC_W+7)'(digit);
   assign carry   = |mac_sum[ACC_W+6:ACC_W];

   always_comb begin
      next_state.phase      = phase_next;
      next_state.acc        = take_digit ? mac_sum[ACC_W-1:0] : cur_state.acc;
      next_state.negative   = take_sign ? (char_code == CHAR_MINUS) : cur_state.negative;
      next_state.overflowed = cur_state.overflowed | (take_digit & carry);
   end

   assign literal_ok = (phase_next == PH_INT) || (phase_next == PH_TAIL);

   always_comb begin
      result.valid_res = literal_ok;
      result.overflow  = literal_ok & next_state.overflowed;
      if (!literal_ok) begin
         result.value = '0;
      end else if (next_state.negative) begin
         result.value = ACC_W'(0) - next_state.acc;
      end else begin
         result.value = next_state.acc;
      end
   end

endmodule

[hdl/rip_skid.sv]
// Two-entry output buffer for results: output register plus skid register.
`timescale 1ns / 1ps

module rip_skid
   import rip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff;
   logic       main_valid_in;
   result_type main_ff;
   result_type main_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_ff;
   result_type skid_in;
   logic       push;
   logic       main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[hdl/radix_integer_parser.sv]
// Top level of the streaming radix integer parser.
`timescale 1ns / 1ps

// The block parses signed integers from a character stream, one character per
// req transaction; req_tlast marks the final character of a string. Each string
// may hold leading blanks, an optional sign, digits of the current radix (letters
// in either case for values above nine) and trailing blanks.
// Only the final character of a string produces a rsp transaction, carrying the
// two's complement value in rsp_tdata and the valid and overflow flags in rsp_tuser.
// The csr channel writes the radix; writes below 2 or above 36 are clamped. It
// must only be written while no string is in progress and no result is pending.
// Throughput is one character per cycle while req_tready is high: the whole
// step (digit decode, one 64-by-6 multiply-add with carry-out test, phase update)
// sits between the string state registers and the result buffer. A result is
// registered in the output buffer before it appears on rsp.
// Results go through a two-entry output buffer, so req_tready depends only on a
// register; when the receiver stalls, one more result is absorbed before
// req_tready drops.
// Reset sets the radix to 10, clears the string state and empties the buffer.
module radix_integer_parser
   import rip_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Character input.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] char_code
   input  logic                 req_tlast,   // last_char
   // Parse results.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,   // [63:0] value
   output logic [1:0]           rsp_tuser,   // [0] valid_res, [1] overflow
   // Radix register write.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [RADIX_W-1:0]   csr_wdata    // radix
);

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   parse_state_type    state_ff;
   parse_state_type    state_in;
   parse_state_type    step_state;
   result_type         step_result;
   result_type         rsp_result;
   logic               req_accept;
   logic               buf_ready;

   // The radix register is always writable; out-of-range values are clamped.
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         if (csr_wdata < RADIX_MIN) radix_in = RADIX_MIN;
         else if (csr_wdata > RADIX_MAX) radix_in = RADIX_MAX;
         else radix_in = csr_wdata;
      end
   end

   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && req_tready;

   rip_step u_step (
      .char_code  (req_tdata),
      .radix      (radix_ff),
      .cur_state  (state_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   // The string state clears after the final character so the next string
   // starts fresh.
   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         state_in = req_tlast ? STATE_CLEAR : step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         state_ff <= STATE_CLEAR;
      end else begin
         radix_ff <= radix_in;
         state_ff <= state_in;
      end
   end

   rip_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept && req_tlast),
      .in_ready  (buf_ready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = rsp_result.value;
   assign rsp_tuser = {rsp_result.overflow, rsp_result.valid_res};

`ifndef NO_ASSERTIONS
   // An overflow is only reported for a well-formed literal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || !rsp_tuser[1]))
      else $error("overflow flagged on an invalid literal");

   // An invalid literal always reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("invalid literal carries a nonzero value");

   // The final character of a string leaves the string state cleared.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=>
         (state_ff.phase == PH_LEAD && state_ff.acc == '0 &&
          !state_ff.negative && !state_ff.overflowed))
      else $error("string state not cleared after final character");

   // The stored radix never leaves the legal range.
   assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX))
      else $error("radix register out of range");
`endif

endmodule
